/* rtl/gbn_pkg.sv */
`default_nettype none
package gbn_pkg;

  localparam int SEQ_W      = 3;
  localparam int TICK_W     = 16;
  localparam int LEN_W      = 9;
  localparam int FUNC_W     = 3;
  localparam int KIND_W     = 2;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  localparam logic [SEQ_W-1:0]  SEQ_MAX     = 3'd7;
  localparam logic [LEN_W-1:0]  MIN_LEN     = 9'd5;
  localparam logic [LEN_W-1:0]  HDR_BYTES   = 9'd7;
  localparam logic [LEN_W-1:0]  MAX_PAYLOAD = 9'd256;
  localparam logic [TICK_W-1:0] DATA_TO_RST = 16'd2000;
  localparam logic [TICK_W-1:0] ACK_DLY_RST = 16'd240;

  localparam logic [FUNC_W-1:0] EV_PKT_READY = 3'd0;
  localparam logic [FUNC_W-1:0] EV_PHY_READY = 3'd1;
  localparam logic [FUNC_W-1:0] EV_FRAME_IN  = 3'd2;
  localparam logic [FUNC_W-1:0] EV_DATA_TO   = 3'd3;
  localparam logic [FUNC_W-1:0] EV_ACK_TO    = 3'd4;

  localparam logic [KIND_W-1:0] FK_DATA = 2'd0;
  localparam logic [KIND_W-1:0] FK_ACK  = 2'd1;
  localparam logic [KIND_W-1:0] FK_NAK  = 2'd2;

  localparam logic CFG_DATA_TO = 1'b0;
  localparam logic CFG_ACK_DLY = 1'b1;

  typedef enum logic [2:0] {
    ACT_SEND_DATA = 3'd0,
    ACT_SEND_ACK  = 3'd1,
    ACT_SEND_NAK  = 3'd2,
    ACT_STOP_TMR  = 3'd3,
    ACT_START_ACK = 3'd4,
    ACT_DELIVER   = 3'd5,
    ACT_STATUS    = 3'd6
  } action_t;

  typedef struct packed {
    logic    latch;
    logic    emit;
    action_t action;
    logic    inc_buf;
    logic    inc_next;
    logic    slide;
    logic    set_phy;
    logic    set_nak;
    logic    inc_exp;
    logic    gb_init;
    logic    inc_cnt;
  } gbn_cmd_t;

  typedef struct packed {
    logic              out_free;
    logic [FUNC_W-1:0] func;
    logic [KIND_W-1:0] kind;
    logic              win_hit;
    logic              nak_hit;
    logic              buf_full;
    logic              bad_frame;
    logic              seq_match;
    logic              nak_allowed;
    logic              gb_more;
  } gbn_stat_t;

  function automatic logic in_window(input logic [SEQ_W-1:0] a,
                                     input logic [SEQ_W-1:0] b,
                                     input logic [SEQ_W-1:0] c);
    return (a <= b && b < c) || (c < a && a <= b) || (b < c && c < a);
  endfunction

endpackage
`default_nettype wire

/* rtl/go_back_n_link_controller.sv */
// Channel  Dir  Ports                         Word
// in_      in   in_tvalid/tready/tdata[23:0]  one link event
// out_     out  out_tvalid/tready/tdata[31:0]/tuser[2:0]/tlast  one link command
// cfg_     in   cfg_we/addr/wdata[15:0]       timer durations, 0 data, 1 ack delay
//
// An event emits N commands, N = 1..11, one command per cycle from the sequencer
// while out_tready stays high; a good received frame closes its ack slide in a
// state that emits nothing, and a resend closes its loop the same way.
// The next event is taken once its status word is loaded in the output register.
// Synchronous active-low reset; timers come back at 2000 and 240 ticks.
// A stalled output holds the sequencer in place; nothing is dropped.
`default_nettype none
module go_back_n_link_controller
  import gbn_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // func, frame_kind, rx_ack, frame_seq, frame_len, crc_good, zero pad
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // seq_num, ack_num, timer_ticks, deliver_len, net_enable
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // action
  output logic [2:0]                 out_tuser,
  output logic                       out_tlast,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_addr,
  input  wire logic [TICK_W-1:0]     cfg_wdata
);

  gbn_cmd_t  cmd;
  gbn_stat_t stat;

  gbn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  gbn_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

`ifndef NO_ASSERTIONS
  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("event accepted while another is in flight");

  a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tuser == ACT_STATUS)))
    else $error("tlast does not match status word");

  a_accept_after_status: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> !out_tvalid || out_tlast)
    else $error("event accepted before previous run closed");
`endif

endmodule
`default_nettype wire

/* rtl/gbn_ctrl.sv */
`default_nettype none
module gbn_ctrl
  import gbn_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  output logic           in_tready,
  input  wire gbn_stat_t stat,
  output gbn_cmd_t       cmd
);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_EVAL     = 11'b000_0000_0010,
    S_PKT      = 11'b000_0000_0100,
    S_ACKTO    = 11'b000_0000_1000,
    S_BADNAK   = 11'b000_0001_0000,
    S_SLIDE    = 11'b000_0010_0000,
    S_RXREPLY  = 11'b000_0100_0000,
    S_DELIVER  = 11'b000_1000_0000,
    S_ACKSTART = 11'b001_0000_0000,
    S_GOBACK   = 11'b010_0000_0000,
    S_STATUS   = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        case (stat.func)
          EV_PKT_READY: state_nxt = stat.buf_full ? S_STATUS : S_PKT;
          EV_PHY_READY: begin
            cmd.set_phy = 1'b1;
            state_nxt   = S_STATUS;
          end
          EV_FRAME_IN: begin
            if (stat.bad_frame) begin
              state_nxt = stat.nak_allowed ? S_BADNAK : S_STATUS;
            end else begin
              state_nxt = S_SLIDE;
            end
          end
          EV_DATA_TO: begin
            cmd.gb_init = 1'b1;
            state_nxt   = S_GOBACK;
          end
          EV_ACK_TO: state_nxt = S_ACKTO;
          default:   state_nxt = S_STATUS;
        endcase
      end
      S_PKT: begin
        if (stat.out_free) begin
          cmd.emit     = 1'b1;
          cmd.action   = ACT_SEND_DATA;
          cmd.inc_buf  = 1'b1;
          cmd.inc_next = 1'b1;
          state_nxt    = S_STATUS;
        end
      end
      S_ACKTO: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.action = ACT_SEND_ACK;
          state_nxt  = S_STATUS;
        end
      end
      S_BADNAK: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.action = ACT_SEND_NAK;
          state_nxt  = S_STATUS;
        end
      end
      S_SLIDE: begin
        if (stat.win_hit) begin
          if (stat.out_free) begin
            cmd.emit   = 1'b1;
            cmd.action = ACT_STOP_TMR;
            cmd.slide  = 1'b1;
          end
        end else if (stat.kind == FK_DATA) begin
          state_nxt = S_RXREPLY;
        end else if (stat.kind == FK_NAK && stat.nak_hit) begin
          cmd.gb_init = 1'b1;
          state_nxt   = S_GOBACK;
        end else begin
          state_nxt = S_STATUS;
        end
      end
      S_RXREPLY: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.action = (!stat.seq_match && stat.nak_allowed) ? ACT_SEND_NAK : ACT_START_ACK;
          state_nxt  = stat.seq_match ? S_DELIVER : S_STATUS;
        end
      end
      S_DELIVER: begin
        if (stat.out_free) begin
          cmd.emit    = 1'b1;
          cmd.action  = ACT_DELIVER;
          cmd.set_nak = 1'b1;
          cmd.inc_exp = 1'b1;
          state_nxt   = S_ACKSTART;
        end
      end
      S_ACKSTART: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.action = ACT_START_ACK;
          state_nxt  = S_STATUS;
        end
      end
      S_GOBACK: begin
        if (!stat.gb_more) begin
          state_nxt = S_STATUS;
        end else if (stat.out_free) begin
          cmd.emit     = 1'b1;
          cmd.action   = ACT_SEND_DATA;
          cmd.inc_next = 1'b1;
          cmd.inc_cnt  = 1'b1;
        end
      end
      S_STATUS: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.action = ACT_STATUS;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/gbn_dpath.sv */
`default_nettype none
module gbn_dpath
  import gbn_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_addr,
  input  wire logic [TICK_W-1:0]     cfg_wdata,
  input  wire gbn_cmd_t              cmd,
  output gbn_stat_t                  stat,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic [2:0]                 out_tuser,
  output logic                       out_tlast
);

  // latched event
  logic [FUNC_W-1:0] func_r;
  logic [KIND_W-1:0] kind_r;
  logic [SEQ_W-1:0]  fack_r, fseq_r;
  logic [LEN_W-1:0]  flen_r;
  logic              crc_r;

  // config
  logic [TICK_W-1:0] data_to_r, ack_dly_r;

  // link state
  logic [SEQ_W-1:0] next_r, next_nxt;
  logic [SEQ_W-1:0] base_r, base_nxt;
  logic [SEQ_W-1:0] buf_r, buf_nxt;
  logic [SEQ_W-1:0] exp_r, exp_nxt;
  logic [SEQ_W-1:0] cnt_r, cnt_nxt;
  logic             phy_r, phy_nxt;
  logic             nak_r, nak_nxt;

  // output word
  logic              oval_r;
  action_t           oact_r;
  logic [SEQ_W-1:0]  oseq_r, oack_r;
  logic [TICK_W-1:0] otick_r;
  logic [LEN_W-1:0]  olen_r;
  logic              one_r, olast_r;
  logic [SEQ_W-1:0]  oseq_nxt, oack_nxt;
  logic [TICK_W-1:0] otick_nxt;
  logic [LEN_W-1:0]  olen_nxt;
  logic              one_nxt, olast_nxt;

  logic [LEN_W-1:0] dlen_raw, dlen;
  logic             is_tx;

  assign dlen_raw = flen_r - HDR_BYTES;
  always_comb begin
    if (flen_r < HDR_BYTES) begin
      dlen = '0;
    end else if (dlen_raw > MAX_PAYLOAD) begin
      dlen = MAX_PAYLOAD;
    end else begin
      dlen = dlen_raw;
    end
  end

  assign is_tx = cmd.emit && (cmd.action == ACT_SEND_DATA || cmd.action == ACT_SEND_ACK ||
                              cmd.action == ACT_SEND_NAK);

  always_comb begin
    stat.out_free    = !oval_r || out_tready;
    stat.func        = func_r;
    stat.kind        = kind_r;
    stat.win_hit     = in_window(base_r, fack_r, next_r);
    stat.nak_hit     = in_window(base_r, fack_r + 3'd1, next_r);
    stat.buf_full    = (buf_r >= SEQ_MAX);
    stat.bad_frame   = (flen_r < MIN_LEN) || !crc_r;
    stat.seq_match   = (fseq_r == exp_r);
    stat.nak_allowed = nak_r;
    stat.gb_more     = (cnt_r < buf_r);
  end

  always_comb begin
    next_nxt = next_r;
    base_nxt = base_r;
    buf_nxt  = buf_r;
    exp_nxt  = exp_r;
    cnt_nxt  = cnt_r;
    phy_nxt  = phy_r;
    nak_nxt  = nak_r;
    if (cmd.gb_init) begin
      next_nxt = base_r;
      cnt_nxt  = '0;
    end else if (cmd.inc_next) begin
      next_nxt = next_r + 3'd1;
    end
    if (cmd.inc_cnt) cnt_nxt = cnt_r + 3'd1;
    if (cmd.slide) begin
      base_nxt = base_r + 3'd1;
      if (buf_r != '0) buf_nxt = buf_r - 3'd1;
    end else if (cmd.inc_buf) begin
      buf_nxt = buf_r + 3'd1;
    end
    if (cmd.inc_exp) exp_nxt = exp_r + 3'd1;
    if (cmd.set_phy) begin
      phy_nxt = 1'b1;
    end else if (is_tx) begin
      phy_nxt = 1'b0;
    end
    if (cmd.set_nak) begin
      nak_nxt = 1'b1;
    end else if (cmd.emit && cmd.action == ACT_SEND_NAK) begin
      nak_nxt = 1'b0;
    end
  end

  always_comb begin
    oseq_nxt  = '0;
    oack_nxt  = '0;
    otick_nxt = '0;
    olen_nxt  = '0;
    one_nxt   = 1'b0;
    olast_nxt = 1'b0;
    case (cmd.action) inside
      ACT_SEND_DATA: begin
        oseq_nxt  = next_r;
        oack_nxt  = exp_r - 3'd1;
        otick_nxt = data_to_r;
      end
      ACT_SEND_ACK, ACT_SEND_NAK: oack_nxt = exp_r - 3'd1;
      ACT_STOP_TMR:  oseq_nxt  = base_r;
      ACT_START_ACK: otick_nxt = ack_dly_r;
      ACT_DELIVER: begin
        oseq_nxt = fseq_r;
        olen_nxt = dlen;
      end
      ACT_STATUS: begin
        one_nxt   = (buf_nxt < SEQ_MAX) && phy_nxt;
        olast_nxt = 1'b1;
      end
      default: olast_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_r    <= '0;
      base_r    <= '0;
      buf_r     <= '0;
      exp_r     <= '0;
      cnt_r     <= '0;
      phy_r     <= 1'b0;
      nak_r     <= 1'b1;
      data_to_r <= DATA_TO_RST;
      ack_dly_r <= ACK_DLY_RST;
      oval_r    <= 1'b0;
    end else begin
      next_r <= next_nxt;
      base_r <= base_nxt;
      buf_r  <= buf_nxt;
      exp_r  <= exp_nxt;
      cnt_r  <= cnt_nxt;
      phy_r  <= phy_nxt;
      nak_r  <= nak_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_DATA_TO: data_to_r <= cfg_wdata;
          CFG_ACK_DLY: ack_dly_r <= cfg_wdata;
          default:     data_to_r <= data_to_r;
        endcase
      end
      if (cmd.emit) begin
        oval_r <= 1'b1;
      end else if (out_tready) begin
        oval_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_r <= in_tdata[2:0];
      kind_r <= in_tdata[4:3];
      fack_r <= in_tdata[7:5];
      fseq_r <= in_tdata[10:8];
      flen_r <= in_tdata[19:11];
      crc_r  <= in_tdata[20];
    end
    if (cmd.emit) begin
      oact_r  <= cmd.action;
      oseq_r  <= oseq_nxt;
      oack_r  <= oack_nxt;
      otick_r <= otick_nxt;
      olen_r  <= olen_nxt;
      one_r   <= one_nxt;
      olast_r <= olast_nxt;
    end
  end

  assign out_tvalid = oval_r;
  assign out_tuser  = oact_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {one_r, olen_r, otick_r, oack_r, oseq_r};

endmodule
`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 1ps
module testbench
  import gbn_pkg::*;
();

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [KIND_W-1:0] kind;
    logic [SEQ_W-1:0]  ack;
    logic [SEQ_W-1:0]  seq;
    logic [LEN_W-1:0]  len;
    logic              crc;
  } link_event_t;

  typedef struct {
    action_t           act;
    logic [SEQ_W-1:0]  seq;
    logic [SEQ_W-1:0]  ack;
    logic [TICK_W-1:0] ticks;
    logic [LEN_W-1:0]  dlen;
    logic              net_en;
    logic              last;
  } link_cmd_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  // func, frame_kind, rx_ack, frame_seq, frame_len, crc_good, zero pad
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  // seq_num, ack_num, timer_ticks, deliver_len, net_enable
  logic [OUT_DATA_W-1:0] out_tdata;
  // action
  logic [2:0]            out_tuser;
  logic                  out_tlast;
  logic                  cfg_we;
  logic                  cfg_addr;
  logic [TICK_W-1:0]     cfg_wdata;

  go_back_n_link_controller dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // link state as the controller should hold it
  logic [SEQ_W-1:0]  snd_next;
  logic [SEQ_W-1:0]  win_base;
  logic [SEQ_W-1:0]  buf_cnt;
  logic [SEQ_W-1:0]  exp_seq;
  logic              phy_rdy;
  logic              nak_ok;
  logic [TICK_W-1:0] data_to;
  logic [TICK_W-1:0] ack_dly;

  link_cmd_t pending_cmds[$];

  int  errors;
  int  events_sent;
  int  cmds_checked;
  int  cycles;
  int  hold_reqs;
  int  hold_served;
  int  rx_wait;
  bit  tx_quiet;
  bit  rx_quiet;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // b lies in [a, c) going around the sequence ring
  function automatic bit seq_between(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b,
                                     logic [SEQ_W-1:0] c);
    logic [SEQ_W-1:0] db;
    logic [SEQ_W-1:0] dc;
    db = b - a;
    dc = c - a;
    return db < dc;
  endfunction

  function automatic void push_cmd(action_t act, logic [SEQ_W-1:0] seq,
                                   logic [SEQ_W-1:0] ack, logic [TICK_W-1:0] ticks,
                                   logic [LEN_W-1:0] dlen, logic net_en, logic last);
    link_cmd_t c;
    c.act = act;
    c.seq = seq;
    c.ack = ack;
    c.ticks = ticks;
    c.dlen = dlen;
    c.net_en = net_en;
    c.last = last;
    pending_cmds.push_back(c);
  endfunction

  function automatic void emit_data_frame(logic [SEQ_W-1:0] seq);
    push_cmd(ACT_SEND_DATA, seq, exp_seq - 3'd1, data_to, '0, 1'b0, 1'b0);
    phy_rdy = 1'b0;
  endfunction

  function automatic void emit_ctrl_frame(action_t act);
    push_cmd(act, '0, exp_seq - 3'd1, '0, '0, 1'b0, 1'b0);
    if (act == ACT_SEND_NAK) nak_ok = 1'b0;
    phy_rdy = 1'b0;
  endfunction

  function automatic void resend_window();
    int i;
    snd_next = win_base;
    for (i = 0; i < buf_cnt; i++) begin
      emit_data_frame(snd_next);
      snd_next = snd_next + 3'd1;
    end
  endfunction

  function automatic void predict_frame(link_event_t e);
    int guard;
    logic [LEN_W-1:0] dlen;
    if (e.len < MIN_LEN || !e.crc) begin
      if (nak_ok) emit_ctrl_frame(ACT_SEND_NAK);
      return;
    end
    for (guard = 0; guard < 8 && seq_between(win_base, e.ack, snd_next); guard++) begin
      if (buf_cnt != 0) buf_cnt = buf_cnt - 3'd1;
      push_cmd(ACT_STOP_TMR, win_base, '0, '0, '0, 1'b0, 1'b0);
      win_base = win_base + 3'd1;
    end
    if (e.kind == FK_DATA) begin
      if (e.seq != exp_seq && nak_ok) emit_ctrl_frame(ACT_SEND_NAK);
      else push_cmd(ACT_START_ACK, '0, '0, ack_dly, '0, 1'b0, 1'b0);
      if (e.seq == exp_seq) begin
        dlen = (e.len < HDR_BYTES) ? '0 : e.len - HDR_BYTES;
        if (dlen > MAX_PAYLOAD) dlen = MAX_PAYLOAD;
        push_cmd(ACT_DELIVER, e.seq, '0, '0, dlen, 1'b0, 1'b0);
        nak_ok = 1'b1;
        exp_seq = exp_seq + 3'd1;
        push_cmd(ACT_START_ACK, '0, '0, ack_dly, '0, 1'b0, 1'b0);
      end
    end
    if (e.kind == FK_NAK && seq_between(win_base, e.ack + 3'd1, snd_next)) resend_window();
  endfunction

  function automatic void predict_event(link_event_t e);
    case (e.func)
      EV_PKT_READY: begin
        if (buf_cnt < SEQ_MAX) begin
          buf_cnt = buf_cnt + 3'd1;
          emit_data_frame(snd_next);
          snd_next = snd_next + 3'd1;
        end
      end
      EV_PHY_READY: phy_rdy = 1'b1;
      EV_FRAME_IN:  predict_frame(e);
      EV_DATA_TO:   resend_window();
      EV_ACK_TO:    emit_ctrl_frame(ACT_SEND_ACK);
      default: ;
    endcase
    push_cmd(ACT_STATUS, '0, '0, '0, '0, (buf_cnt < SEQ_MAX) && phy_rdy, 1'b1);
  endfunction

  function automatic link_event_t make_event(logic [FUNC_W-1:0] func,
                                             logic [KIND_W-1:0] kind,
                                             logic [SEQ_W-1:0] ack, logic [SEQ_W-1:0] seq,
                                             logic [LEN_W-1:0] len, logic crc);
    link_event_t e;
    e.func = func;
    e.kind = kind;
    e.ack = ack;
    e.seq = seq;
    e.len = len;
    e.crc = crc;
    return e;
  endfunction

  // mostly legal traffic shaped by the current window, some raw noise
  function automatic link_event_t random_event();
    link_event_t e;
    logic [SEQ_W-1:0] off;
    int r;
    e.func = FUNC_W'($urandom_range(0, 7));
    e.kind = KIND_W'($urandom_range(0, 3));
    e.ack = SEQ_W'($urandom_range(0, 7));
    e.seq = SEQ_W'($urandom_range(0, 7));
    e.len = LEN_W'($urandom_range(0, 511));
    e.crc = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < 15) return e;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      e.func = EV_PKT_READY;
    end else if (r < 40) begin
      e.func = EV_PHY_READY;
    end else if (r < 78) begin
      e.func = EV_FRAME_IN;
      e.crc = ($urandom_range(0, 19) != 0);
      e.len = LEN_W'($urandom_range(HDR_BYTES, HDR_BYTES + MAX_PAYLOAD));
      r = $urandom_range(0, 3);
      e.kind = (r < 2) ? FK_DATA : (r == 2) ? FK_ACK : FK_NAK;
      off = SEQ_W'($urandom_range(0, buf_cnt));
      e.ack = win_base + off - 3'd1;
      if ($urandom_range(0, 3) != 0) e.seq = exp_seq;
    end else if (r < 89) begin
      e.func = EV_DATA_TO;
    end else begin
      e.func = EV_ACK_TO;
    end
    return e;
  endfunction

  task automatic send_event(link_event_t e);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata <= {3'b000, e.crc, e.len, e.seq, e.ack, e.kind, e.func};
    do @(posedge clk); while (!in_tready);
    predict_event(e);
    events_sent++;
    gap = pick_gap(tx_quiet);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_cmds.size() != 0);
  endtask

  task automatic set_timers(logic [TICK_W-1:0] data_ticks, logic [TICK_W-1:0] ack_ticks);
    wait_idle();
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= CFG_DATA_TO;
    cfg_wdata <= data_ticks;
    @(posedge clk);
    data_to = data_ticks;
    cfg_addr <= CFG_ACK_DLY;
    cfg_wdata <= ack_ticks;
    @(posedge clk);
    ack_dly = ack_ticks;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : cmd_checker
    link_cmd_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_cmds.size() == 0) begin
        $error("action: expected none, got %0d", out_tuser);
        errors++;
      end else begin
        want = pending_cmds.pop_front();
        check_field("action", int'(want.act), int'(out_tuser));
        check_field("seq_num", int'(want.seq), int'(out_tdata[2:0]));
        check_field("ack_num", int'(want.ack), int'(out_tdata[5:3]));
        check_field("timer_ticks", int'(want.ticks), int'(out_tdata[21:6]));
        check_field("deliver_len", int'(want.dlen), int'(out_tdata[30:22]));
        check_field("net_enable", int'(want.net_en), int'(out_tdata[31]));
        check_field("last", int'(want.last), int'(out_tlast));
        cmds_checked++;
      end
    end
  end

  always @(posedge clk) begin : rx_side
    int g;
    if (hold_served != hold_reqs) begin
      hold_served <= hold_reqs;
      rx_wait <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      out_tready <= 1'b0;
    end else begin
      g = pick_gap(rx_quiet);
      out_tready <= (g == 0);
      rx_wait <= (g > 0) ? g - 1 : 0;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("go_back_n_link_controller verification failed");
      $finish;
    end
  end

  // fill the window past full, then time out, nak and ack it empty again, then an ack timeout
  task automatic test_window_and_timeouts();
    int i;
    send_event(make_event(EV_PHY_READY, FK_DATA, 3'd0, 3'd0, 9'd0, 1'b0));
    for (i = 0; i < 8; i++)
      send_event(make_event(EV_PKT_READY, FK_DATA, 3'd0, 3'd0, 9'd0, 1'b0));
    send_event(make_event(EV_DATA_TO, FK_DATA, 3'd0, 3'd0, 9'd0, 1'b0));
    send_event(make_event(EV_FRAME_IN, FK_NAK, win_base, 3'd0, 9'd7, 1'b1));
    send_event(make_event(EV_FRAME_IN, FK_ACK, snd_next - 3'd1, 3'd0, 9'd7, 1'b1));
    send_event(make_event(EV_ACK_TO, FK_DATA, 3'd0, 3'd0, 9'd0, 1'b0));
  endtask

  // bad frames, nak suppression, payload length clamps, odd kinds and events
  task automatic test_frame_handling();
    send_event(make_event(EV_FRAME_IN, FK_DATA, 3'd7, exp_seq, 9'd100, 1'b0));
    send_event(make_event(EV_FRAME_IN, FK_DATA, 3'd7, exp_seq, 9'd4, 1'b1));
    send_event(make_event(EV_FRAME_IN, FK_DATA, 3'd7, exp_seq + 3'd5, 9'd20, 1'b1));
    send_event(make_event(EV_FRAME_IN, FK_DATA, 3'd7, exp_seq, 9'd5, 1'b1));
    send_event(make_event(EV_FRAME_IN, FK_DATA, 3'd7, exp_seq, 9'd511, 1'b1));
    send_event(make_event(EV_FRAME_IN, FK_DATA, 3'd7, exp_seq, 9'd263, 1'b1));
    send_event(make_event(EV_FRAME_IN, FK_DATA, 3'd7, exp_seq + 3'd3, 9'd30, 1'b1));
    send_event(make_event(EV_FRAME_IN, 2'd3, 3'd7, 3'd7, 9'd300, 1'b1));
    send_event(make_event(3'd5, FK_NAK, 3'd7, 3'd7, 9'd511, 1'b1));
    send_event(make_event(3'd6, FK_ACK, 3'd0, 3'd0, 9'd0, 1'b0));
    send_event(make_event(3'd7, 2'd3, 3'd7, 3'd7, 9'd511, 1'b1));
  endtask

  task automatic test_random_traffic(int n, logic [TICK_W-1:0] data_ticks,
                                     logic [TICK_W-1:0] ack_ticks);
    int i;
    set_timers(data_ticks, ack_ticks);
    for (i = 0; i < n; i++) begin
      tx_quiet = (i >= n / 3 && i < n / 3 + 20);
      rx_quiet = tx_quiet;
      send_event(random_event());
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  // output held off while events keep coming, then sender waits for drain
  task automatic test_backpressure();
    int i;
    wait_idle();
    hold_reqs++;
    tx_quiet = 1'b1;
    send_event(make_event(EV_PHY_READY, FK_DATA, 3'd0, 3'd0, 9'd0, 1'b0));
    for (i = 0; i < 24; i++)
      send_event(make_event((i % 3 == 2) ? EV_DATA_TO : EV_PKT_READY,
                            FK_DATA, 3'd0, 3'd0, 9'd0, 1'b0));
    tx_quiet = 1'b0;
    wait_idle();
  endtask

  initial begin
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    out_tready <= 1'b0;
    cfg_we <= 1'b0;
    cfg_addr <= CFG_DATA_TO;
    cfg_wdata <= '0;
    errors = 0;
    events_sent = 0;
    cmds_checked = 0;
    cycles = 0;
    hold_reqs = 0;
    hold_served = 0;
    rx_wait = 0;
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    snd_next = '0;
    win_base = '0;
    buf_cnt = '0;
    exp_seq = '0;
    phy_rdy = 1'b0;
    nak_ok = 1'b1;
    data_to = DATA_TO_RST;
    ack_dly = ACK_DLY_RST;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_window_and_timeouts();
    test_frame_handling();
    test_random_traffic(80, 16'hFFFF, 16'd1);
    test_backpressure();
    test_random_traffic(80, 16'd1, 16'hFFFF);
    test_random_traffic(80, TICK_W'($urandom_range(1, 65535)),
                        TICK_W'($urandom_range(1, 65535)));
    test_random_traffic(80, DATA_TO_RST, ACK_DLY_RST);

    wait_idle();
    repeat (30) @(posedge clk);
    $display("%0d link events sent, %0d commands checked", events_sent, cmds_checked);
    $display("window fill and timeouts, bad frames, length clamps, timer extremes, long stall");
    if (errors == 0 && pending_cmds.size() == 0) begin
      $display("go_back_n_link_controller verification clean");
    end else begin
      $display("go_back_n_link_controller verification failed");
    end
    $finish;
  end

endmodule
